// ===== rtl/pfb_pkg.sv =====
// Shared types, display geometry and the 5x7 font for the page frame buffer.
// No dependencies; every other file but pfb_ram refers to it by scoped names.
package pfb_pkg;

    localparam int DISPLAY_COLUMNS = 128;
    localparam int DISPLAY_PAGES   = 8;
    localparam int CELL_COLUMNS    = 6;
    localparam int GLYPH_COLUMNS   = 5;
    localparam int CASE_OFFSET     = 32;
    localparam int WORDS_PER_PAGE  = 16;

    localparam int GROUPS   = (DISPLAY_COLUMNS + 7) / 8;
    localparam int WORDS    = DISPLAY_PAGES * GROUPS;
    localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GRP_W    = ($clog2(GROUPS) > 4) ? $clog2(GROUPS) : 4;
    localparam int PG_W     = 3;
    localparam int COL_W    = 9;
    localparam int WORD_W   = 64;

    typedef enum logic [2:0] {
        ACT_FILL     = 3'd0,
        ACT_CLEAR    = 3'd1,
        ACT_CHAR     = 3'd2,
        ACT_CLR_ALL  = 3'd3,
        ACT_MARK_ALL = 3'd4,
        ACT_REFRESH  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_PAGE,
        ST_RD,
        ST_WR,
        ST_REF_RD,
        ST_REF_LD,
        ST_REF_NONE
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic clear_all;
        logic mark_all;
        logic mark;
        logic page_next;
        logic grp_init;
        logic grp_next;
        logic rd;
        logic wr;
        logic ref_start;
        logic ref_none;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       pg_empty;
        logic       col_empty;
        logic       pg_last;
        logic       grp_last;
        logic       dirty_any;
        logic       out_free;
        logic       ref_last;
    } t_stat;

    // Glyph bytes packed with column 0 in the top byte.
    function automatic logic [39:0] font_glyph(input logic [7:0] code);
        logic [7:0]  c;
        logic [39:0] g;
        c = code;
        if (code >= 8'h61 && code <= 8'h7A) c = code - 8'(CASE_OFFSET);
        case (c)
            8'h30: g = 40'h3E_51_49_45_3E;
            8'h31: g = 40'h00_42_7F_40_00;
            8'h32: g = 40'h42_61_51_49_46;
            8'h33: g = 40'h21_41_45_4B_31;
            8'h34: g = 40'h18_14_12_7F_10;
            8'h35: g = 40'h27_45_45_45_39;
            8'h36: g = 40'h3C_4A_49_49_30;
            8'h37: g = 40'h01_71_09_05_03;
            8'h38: g = 40'h36_49_49_49_36;
            8'h39: g = 40'h06_49_49_29_1E;
            8'h41: g = 40'h7E_11_11_11_7E;
            8'h42: g = 40'h7F_49_49_49_36;
            8'h43: g = 40'h3E_41_41_41_22;
            8'h44: g = 40'h7F_41_41_22_1C;
            8'h45: g = 40'h7F_49_49_49_41;
            8'h46: g = 40'h7F_09_09_09_01;
            8'h47: g = 40'h3E_41_49_49_7A;
            8'h48: g = 40'h7F_08_08_08_7F;
            8'h49: g = 40'h00_41_7F_41_00;
            8'h4A: g = 40'h20_40_41_3F_01;
            8'h4B: g = 40'h7F_08_14_22_41;
            8'h4C: g = 40'h7F_40_40_40_40;
            8'h4D: g = 40'h7F_02_0C_02_7F;
            8'h4E: g = 40'h7F_04_08_10_7F;
            8'h4F: g = 40'h3E_41_41_41_3E;
            8'h50: g = 40'h7F_09_09_09_06;
            8'h51: g = 40'h3E_41_51_21_5E;
            8'h52: g = 40'h7F_09_19_29_46;
            8'h53: g = 40'h46_49_49_49_31;
            8'h54: g = 40'h01_01_7F_01_01;
            8'h55: g = 40'h3F_40_40_40_3F;
            8'h56: g = 40'h1F_20_40_20_1F;
            8'h57: g = 40'h3F_40_38_40_3F;
            8'h58: g = 40'h63_14_08_14_63;
            8'h59: g = 40'h07_08_70_08_07;
            8'h5A: g = 40'h61_51_49_45_43;
            8'h25: g = 40'h63_13_08_64_63;
            8'h3A: g = 40'h00_36_36_00_00;
            8'h2D: g = 40'h08_08_08_08_08;
            8'h2E: g = 40'h00_60_60_00_00;
            default: g = 40'h0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/pfb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/pfb_ctrl.sv =====
// Sequencer for the frame buffer: walks pages and column groups, runs refresh.
// Depends on pfb_pkg.
module pfb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pfb_pkg::t_stat i_stat,
    output pfb_pkg::t_cmd  o_cmd
);
    pfb_pkg::t_state r_state, n_state;
    logic accept;

    assign o_stall = (r_state != pfb_pkg::ST_IDLE);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pfb_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pfb_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = pfb_pkg::ST_PREP;
                end
            end
            pfb_pkg::ST_PREP: begin
                n_state = pfb_pkg::ST_IDLE;
                unique case (i_stat.action) inside
                    pfb_pkg::ACT_FILL, pfb_pkg::ACT_CLEAR, pfb_pkg::ACT_CHAR: begin
                        o_cmd.prep = 1'b1;
                        n_state    = pfb_pkg::ST_PAGE;
                    end
                    pfb_pkg::ACT_CLR_ALL: begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.mark_all  = 1'b1;
                    end
                    pfb_pkg::ACT_MARK_ALL: o_cmd.mark_all = 1'b1;
                    pfb_pkg::ACT_REFRESH: begin
                        if (i_stat.dirty_any) begin
                            o_cmd.ref_start = 1'b1;
                            n_state         = pfb_pkg::ST_REF_RD;
                        end else begin
                            n_state = pfb_pkg::ST_REF_NONE;
                        end
                    end
                    default: n_state = pfb_pkg::ST_IDLE;
                endcase
            end
            pfb_pkg::ST_PAGE: begin
                if (i_stat.pg_empty) begin
                    n_state = pfb_pkg::ST_IDLE;
                end else begin
                    o_cmd.mark = 1'b1;
                    if (i_stat.col_empty) begin
                        if (i_stat.pg_last) n_state = pfb_pkg::ST_IDLE;
                        else                o_cmd.page_next = 1'b1;
                    end else begin
                        o_cmd.grp_init = 1'b1;
                        n_state        = pfb_pkg::ST_RD;
                    end
                end
            end
            pfb_pkg::ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = pfb_pkg::ST_WR;
            end
            pfb_pkg::ST_WR: begin
                o_cmd.wr = 1'b1;
                if (i_stat.grp_last) begin
                    if (i_stat.pg_last) begin
                        n_state = pfb_pkg::ST_IDLE;
                    end else begin
                        o_cmd.page_next = 1'b1;
                        n_state         = pfb_pkg::ST_PAGE;
                    end
                end else begin
                    o_cmd.grp_next = 1'b1;
                    n_state        = pfb_pkg::ST_RD;
                end
            end
            pfb_pkg::ST_REF_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = pfb_pkg::ST_REF_LD;
            end
            pfb_pkg::ST_REF_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_stat.ref_last) begin
                        n_state = pfb_pkg::ST_IDLE;
                    end else begin
                        o_cmd.grp_next = 1'b1;
                        n_state        = pfb_pkg::ST_REF_RD;
                    end
                end
            end
            pfb_pkg::ST_REF_NONE: begin
                if (i_stat.out_free) begin
                    o_cmd.ref_none = 1'b1;
                    n_state        = pfb_pkg::ST_IDLE;
                end
            end
            default: n_state = pfb_pkg::ST_IDLE;
        endcase
    end

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfb_pkg::ST_WR |-> $past(r_state) == pfb_pkg::ST_RD)
        else $error("write step without preceding read");

    a_ld_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfb_pkg::ST_REF_LD |->
            ($past(r_state) == pfb_pkg::ST_REF_RD || $past(r_state) == pfb_pkg::ST_REF_LD))
        else $error("refresh load without read");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == pfb_pkg::ST_PREP)
        else $error("accepted beat not decoded");
endmodule

// ===== rtl/pfb_datapath.sv =====
// Item registers, range setup, word merge, valid bits, dirty range and output
// register of the frame buffer. Depends on pfb_pkg and pfb_ram.
module pfb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfb_pkg::t_cmd               i_cmd,
    output pfb_pkg::t_stat              o_stat,
    input  logic [2:0]                  i_action,
    input  logic [7:0]                  i_x,
    input  logic [7:0]                  i_y,
    input  logic [7:0]                  i_width,
    input  logic [7:0]                  i_height,
    input  logic                        i_color,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_invert,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [2:0]                  o_page_index,
    output logic [3:0]                  o_column_group,
    output logic [pfb_pkg::WORD_W-1:0]  o_pixel_bytes,
    output logic                        o_nothing_dirty,
    output logic                        o_last
);
    localparam int COL_W  = pfb_pkg::COL_W;
    localparam int GRP_W  = pfb_pkg::GRP_W;
    localparam int PG_W   = pfb_pkg::PG_W;
    localparam int ADDR_W = pfb_pkg::ADDR_W;
    localparam int WORD_W = pfb_pkg::WORD_W;

    // Captured item.
    logic [2:0] r_act;
    logic [7:0] r_x, r_y, r_w, r_h, r_code;
    logic       r_color, r_inv;

    // Walk ranges.
    logic [COL_W-1:0] r_cend, r_rend;
    logic [PG_W-1:0]  r_pg, r_pg_last, r_dirty_first, r_dirty_last;
    logic [GRP_W-1:0] r_grp, r_grp_first, r_grp_last;
    logic             r_pg_empty, r_col_empty, r_dirty_any;
    logic [39:0]      r_glyph;

    logic [pfb_pkg::WORDS-1:0] r_valid;
    logic                      r_rd_vld;

    logic             r_o_valid, r_o_none, r_o_last;
    logic [2:0]       r_o_page;
    logic [3:0]       r_o_group;
    logic [WORD_W-1:0] r_o_bytes;

    logic [COL_W-1:0]  x9, y9, cend_fill, cend_char, cend_sel, rend_fill, pend_clr;
    logic [COL_W-1:0]  sum_xw, sum_yh, sum_x6;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] rd_data, old_word, mask, val, new_word;
    logic [7:0]        rowbits;
    logic              grp_on_disp;
    logic              pg_ne;
    logic [PG_W-1:0]   pg_first, pg_last;

    function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = g[39:32];
            3'd1:    b = g[31:24];
            3'd2:    b = g[23:16];
            3'd3:    b = g[15:8];
            3'd4:    b = g[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Range setup from captured item.
    always_comb begin
        x9        = {1'b0, r_x};
        y9        = {1'b0, r_y};
        sum_xw    = x9 + {1'b0, r_w};
        sum_yh    = y9 + {1'b0, r_h};
        sum_x6    = x9 + COL_W'(pfb_pkg::CELL_COLUMNS);
        cend_fill = (sum_xw > COL_W'(pfb_pkg::DISPLAY_COLUMNS)) ?
                    COL_W'(pfb_pkg::DISPLAY_COLUMNS) : sum_xw;
        cend_char = (sum_x6 > COL_W'(pfb_pkg::DISPLAY_COLUMNS)) ?
                    COL_W'(pfb_pkg::DISPLAY_COLUMNS) : sum_x6;
        rend_fill = (sum_yh > COL_W'(pfb_pkg::DISPLAY_PAGES * 8)) ?
                    COL_W'(pfb_pkg::DISPLAY_PAGES * 8) : sum_yh;
        pend_clr  = (sum_yh > COL_W'(pfb_pkg::DISPLAY_PAGES)) ?
                    COL_W'(pfb_pkg::DISPLAY_PAGES) : sum_yh;
        cend_sel  = (r_act == pfb_pkg::ACT_CHAR) ? cend_char : cend_fill;
        pg_ne     = 1'b0;
        pg_first  = r_y[PG_W-1:0];
        pg_last   = r_y[PG_W-1:0];
        case (r_act)
            pfb_pkg::ACT_FILL: begin
                pg_ne    = y9 < rend_fill;
                pg_first = PG_W'(y9 >> 3);
                pg_last  = PG_W'((rend_fill - COL_W'(1)) >> 3);
            end
            pfb_pkg::ACT_CLEAR: begin
                pg_ne   = (x9 < COL_W'(pfb_pkg::DISPLAY_COLUMNS)) && (y9 < pend_clr);
                pg_last = PG_W'(pend_clr - COL_W'(1));
            end
            pfb_pkg::ACT_CHAR: begin
                pg_ne = (x9 < COL_W'(pfb_pkg::DISPLAY_COLUMNS)) &&
                        (y9 < COL_W'(pfb_pkg::DISPLAY_PAGES));
            end
            default: pg_ne = 1'b0;
        endcase
    end

    // Word merge for the current page and group.
    always_comb begin
        logic [COL_W:0] col;
        logic [COL_W:0] off;
        logic           incol;
        logic [7:0]     cb;
        for (int i = 0; i < 8; i++) begin
            rowbits[i] = ({1'b0, r_pg, 3'(i)} >= y9) && ({1'b0, r_pg, 3'(i)} < r_rend);
        end
        old_word = r_rd_vld ? rd_data : '0;
        for (int b = 0; b < 8; b++) begin
            col   = (COL_W+1)'({r_grp, 3'(b)});
            off   = col - {2'b00, r_x};
            incol = (col >= {2'b00, r_x}) && (col < {1'b0, r_cend});
            cb    = glyph_col(r_glyph, off[2:0]) ^ {8{r_inv}};
            case (r_act)
                pfb_pkg::ACT_FILL: begin
                    mask[8*b +: 8] = incol ? rowbits : 8'h00;
                    val[8*b +: 8]  = {8{r_color}};
                end
                pfb_pkg::ACT_CHAR: begin
                    mask[8*b +: 8] = {8{incol}};
                    val[8*b +: 8]  = cb;
                end
                default: begin
                    mask[8*b +: 8] = {8{incol}};
                    val[8*b +: 8]  = 8'h00;
                end
            endcase
        end
        new_word = (old_word & ~mask) | (val & mask);
    end

    assign addr        = ADDR_W'(int'(r_pg) * pfb_pkg::GROUPS + int'(r_grp));
    assign grp_on_disp = int'(r_grp) < pfb_pkg::GROUPS;

    pfb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (pfb_pkg::WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (addr),
        .i_wr_data (new_word),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    // Item capture and walk counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_x     <= i_x;
            r_y     <= i_y;
            r_w     <= i_width;
            r_h     <= i_height;
            r_color <= i_color;
            r_code  <= i_char_code;
            r_inv   <= i_invert;
        end
        if (i_cmd.prep) begin
            r_cend      <= cend_sel;
            r_rend      <= rend_fill;
            r_pg        <= pg_first;
            r_pg_last   <= pg_last;
            r_pg_empty  <= !pg_ne;
            r_col_empty <= !(x9 < cend_sel);
            r_grp_first <= GRP_W'(x9 >> 3);
            r_grp_last  <= GRP_W'((cend_sel - COL_W'(1)) >> 3);
            r_glyph     <= pfb_pkg::font_glyph(r_code);
        end
        if (i_cmd.ref_start) begin
            r_pg  <= r_dirty_first;
            r_grp <= '0;
        end
        if (i_cmd.page_next) r_pg  <= r_pg + PG_W'(1);
        if (i_cmd.grp_init)  r_grp <= r_grp_first;
        if (i_cmd.grp_next)  r_grp <= r_grp + GRP_W'(1);
        if (i_cmd.rd)        r_rd_vld <= grp_on_disp && r_valid[addr];
    end

    // Valid bits: an unwritten or cleared word reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) r_valid <= '0;
        else if (i_cmd.wr)               r_valid[addr] <= 1'b1;
    end

    // Dirty page range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty_any   <= 1'b0;
            r_dirty_first <= '0;
            r_dirty_last  <= '0;
        end else if (i_cmd.mark_all) begin
            r_dirty_any   <= 1'b1;
            r_dirty_first <= '0;
            r_dirty_last  <= PG_W'(pfb_pkg::DISPLAY_PAGES - 1);
        end else if (i_cmd.mark) begin
            r_dirty_any <= 1'b1;
            if (!r_dirty_any || r_pg < r_dirty_first) r_dirty_first <= r_pg;
            if (!r_dirty_any || r_pg > r_dirty_last)  r_dirty_last  <= r_pg;
        end else if (i_cmd.ref_start) begin
            if (r_dirty_first >= r_dirty_last) begin
                r_dirty_any   <= 1'b0;
                r_dirty_first <= '0;
                r_dirty_last  <= '0;
            end else begin
                r_dirty_first <= r_dirty_first + PG_W'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.ref_none) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_page  <= 3'(r_pg);
            r_o_group <= r_grp[3:0];
            r_o_bytes <= old_word;
            r_o_none  <= 1'b0;
            r_o_last  <= (r_grp[3:0] == 4'(pfb_pkg::WORDS_PER_PAGE - 1));
        end else if (i_cmd.ref_none) begin
            r_o_page  <= '0;
            r_o_group <= '0;
            r_o_bytes <= '0;
            r_o_none  <= 1'b1;
            r_o_last  <= 1'b0;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_page_index    = r_o_page;
    assign o_column_group  = r_o_group;
    assign o_pixel_bytes   = r_o_bytes;
    assign o_nothing_dirty = r_o_none;
    assign o_last          = r_o_last;

    assign o_stat.action    = r_act;
    assign o_stat.pg_empty  = r_pg_empty;
    assign o_stat.col_empty = r_col_empty;
    assign o_stat.pg_last   = (r_pg == r_pg_last);
    assign o_stat.grp_last  = (r_grp == r_grp_last);
    assign o_stat.dirty_any = r_dirty_any;
    assign o_stat.out_free  = !r_o_valid || !i_stall;
    assign o_stat.ref_last  = (r_grp[3:0] == 4'(pfb_pkg::WORDS_PER_PAGE - 1));

    a_dirty_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty_any |-> r_dirty_first <= r_dirty_last)
        else $error("dirty range inverted");

    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_none |-> r_o_bytes == '0 && !r_o_last)
        else $error("empty refresh beat carries data");

    a_wr_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> $past(i_cmd.rd))
        else $error("merge write without fresh read");
endmodule

// ===== rtl/page_framebuffer_draw_engine.sv =====
// Fill, clear and char walk the touched pages and, per page, the touched 8-column groups;
// a character touches one page and one or two 8-column groups.
// Refresh sends 16 beats for one dirty page, or one empty beat if nothing is dirty.
// Throughput: one item at a time; the read-modify-write over the word RAM sets it.
// Reset: synchronous, active low; valid bits clear at once, no clearing pass.
// Depends on pfb_pkg, pfb_ram, pfb_ctrl and pfb_datapath.
module page_framebuffer_draw_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Draw item channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_action,
    input  logic [7:0]                  i_x,
    input  logic [7:0]                  i_y,
    input  logic [7:0]                  i_width,
    input  logic [7:0]                  i_height,
    input  logic                        i_color,
    input  logic [7:0]                  i_char_code,
    input  logic                        i_invert,
    // Refresh word channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_page_index,
    output logic [3:0]                  o_column_group,
    output logic [pfb_pkg::WORD_W-1:0]  o_pixel_bytes,
    output logic                        o_nothing_dirty,
    output logic                        o_last
);
    // Frame memory is held as 64-bit words, one per page and group of eight
    // columns, so a refresh beat is one RAM read. Drawing merges a byte-lane
    // mask into each touched word. A per-word valid bit makes unwritten words
    // read as zero, which also gives clear-all without a pass over the RAM.
    pfb_pkg::t_cmd  cmd;
    pfb_pkg::t_stat stat;

    pfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the item, walk pages and groups, drive the output beat.
    pfb_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_x             (i_x),
        .i_y             (i_y),
        .i_width         (i_width),
        .i_height        (i_height),
        .i_color         (i_color),
        .i_char_code     (i_char_code),
        .i_invert        (i_invert),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_page_index    (o_page_index),
        .o_column_group  (o_column_group),
        .o_pixel_bytes   (o_pixel_bytes),
        .o_nothing_dirty (o_nothing_dirty),
        .o_last          (o_last)
    );
endmodule
